[design/key_set_table_search_insert_remove_assert.svh]
// Assertion macros for the key set table checker.
// Used by kst_checker; expects clk and arst_n in scope.
`ifndef KEY_SET_TABLE_SEARCH_INSERT_REMOVE_ASSERT_SVH
`define KEY_SET_TABLE_SEARCH_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key set table check failed");

// next-cycle implication, checked out of reset
`define KST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key set table check failed");

`endif

[design/kst_pkg.sv]
// Shared constants, codes and types of the key set table.
// No dependencies; used by kst_ctrl, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int KW    = 31;
	localparam int RW    = 7;
	localparam int CAPW  = 7;
	localparam int CMPW  = (CW > CAPW) ? CW : CAPW;

	localparam logic [1:0] ACT_SEARCH = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic CFG_ORDERED  = 1'b0;
	localparam logic CFG_CAPACITY = 1'b1;

	localparam logic [CAPW-1:0] CAP_RESET = 7'd64;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_FULL     = 3'd2,
		ST_DUP      = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [KW-1:0] wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic          valid;
		status_t       status;
		logic [CW-1:0] position;
		logic [CW-1:0] count;
	} result_t;

endpackage

`default_nettype wire

[design/kst_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/kst_ctrl.sv]
// Sequencer of the key set table: search, shift and move passes over the key RAM.
// Depends on kst_pkg; drives the RAM request and the result toward the top level.
`timescale 1ns / 1ps
`default_nettype none

module kst_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire  [1:0]              in_action,
	input  wire  [kst_pkg::KW-1:0]  in_key,
	input  wire                     ordered,
	input  wire  [kst_pkg::CW-1:0]  cap_eff,
	input  wire                     out_free,
	output kst_pkg::mem_req_t       mem_req,
	input  wire  [kst_pkg::KW-1:0]  rdata,
	output kst_pkg::result_t        res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_BREAD,
		S_BCMP,
		S_SHUP,
		S_SHDN,
		S_MVRD,
		S_MVWR,
		S_RESP
	} state_t;

	state_t                    state_q;
	logic [1:0]                act_q;
	logic [kst_pkg::KW-1:0]    key_q;
	logic [kst_pkg::CW-1:0]    cnt_q;
	logic [kst_pkg::CW-1:0]    newcnt_q;
	logic [kst_pkg::CW-1:0]    ptr_q;
	logic [kst_pkg::CW-1:0]    pos_q;
	logic [kst_pkg::CW-1:0]    lo_q;
	logic [kst_pkg::CW-1:0]    hi_q;
	logic [kst_pkg::CW-1:0]    mid_s1;
	logic [kst_pkg::CW-1:0]    addr_s1;
	logic                      valid_s1;
	kst_pkg::status_t          status_q;

	logic [kst_pkg::CW:0]      lohi_sum;
	logic [kst_pkg::CW-1:0]    mid;
	logic [kst_pkg::CW:0]      ptr_p1;
	logic [kst_pkg::CW-1:0]    ptr_m1;
	logic [kst_pkg::CW-1:0]    cnt_m1;
	logic [kst_pkg::CW-1:0]    cnt_p1;
	logic                      find_done;
	logic                      find_hit;
	logic [kst_pkg::CW-1:0]    find_pos;

	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = lohi_sum[kst_pkg::CW:1];
	assign ptr_p1   = {1'b0, ptr_q} + {{kst_pkg::CW{1'b0}}, 1'b1};
	assign ptr_m1   = ptr_q - {{(kst_pkg::CW-1){1'b0}}, 1'b1};
	assign cnt_m1   = cnt_q - {{(kst_pkg::CW-1){1'b0}}, 1'b1};
	assign cnt_p1   = cnt_q + {{(kst_pkg::CW-1){1'b0}}, 1'b1};

	assign in_ready = (state_q == S_IDLE);

	// end of the search pass, hit or miss
	always_comb begin
		find_done = 1'b0;
		find_hit  = 1'b0;
		find_pos  = cnt_q;
		case (state_q)
			S_SCAN: begin
				if (valid_s1 && rdata == key_q) begin
					find_done = 1'b1;
					find_hit  = 1'b1;
					find_pos  = addr_s1;
				end else if (!valid_s1 && ptr_q == cnt_q) begin
					find_done = 1'b1;
				end
			end
			S_BREAD: begin
				if (lo_q == hi_q) begin
					find_done = 1'b1;
					find_pos  = lo_q;
				end
			end
			S_BCMP: begin
				if (rdata == key_q) begin
					find_done = 1'b1;
					find_hit  = 1'b1;
					find_pos  = mid_s1;
				end
			end
			default: begin
				find_done = 1'b0;
			end
		endcase
	end

	// RAM requests; a shift pass reads one entry ahead of the one it writes,
	// so a read never meets a pending write to the same entry
	always_comb begin
		mem_req       = '0;
		mem_req.wdata = rdata;
		mem_req.waddr = addr_s1[kst_pkg::AW-1:0];
		case (state_q)
			S_SCAN: begin
				mem_req.re    = (ptr_q < cnt_q);
				mem_req.raddr = ptr_q[kst_pkg::AW-1:0];
			end
			S_BREAD: begin
				mem_req.re    = (lo_q != hi_q);
				mem_req.raddr = mid[kst_pkg::AW-1:0];
			end
			S_SHUP: begin
				mem_req.re    = (ptr_q > pos_q);
				mem_req.raddr = ptr_m1[kst_pkg::AW-1:0];
				if (valid_s1) begin
					mem_req.we = 1'b1;
				end else if (ptr_q == pos_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_q[kst_pkg::AW-1:0];
					mem_req.wdata = key_q;
				end
			end
			S_SHDN: begin
				mem_req.re    = (ptr_p1 < {1'b0, cnt_q});
				mem_req.raddr = ptr_p1[kst_pkg::AW-1:0];
				mem_req.we    = valid_s1;
			end
			S_MVRD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = cnt_m1[kst_pkg::AW-1:0];
			end
			S_MVWR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q[kst_pkg::AW-1:0];
			end
			default: begin
				mem_req.re = 1'b0;
			end
		endcase
	end

	assign res.valid    = (state_q == S_RESP) && out_free;
	assign res.status   = status_q;
	assign res.position = pos_q;
	assign res.count    = newcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			// drop any read in flight once the search pass settles
			valid_s1 <= mem_req.re && !find_done &&
				(state_q == S_SCAN || state_q == S_SHUP || state_q == S_SHDN);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q    <= in_action;
						key_q    <= in_key;
						newcnt_q <= cnt_q;
						ptr_q    <= '0;
						lo_q     <= '0;
						hi_q     <= cnt_q;
						if (in_action == kst_pkg::ACT_INSERT && cnt_q >= cap_eff) begin
							status_q <= kst_pkg::ST_FULL;
							pos_q    <= cnt_q;
							state_q  <= S_RESP;
						end else if (in_action == kst_pkg::ACT_REMOVE && cnt_q == '0) begin
							status_q <= kst_pkg::ST_EMPTY;
							pos_q    <= '0;
							state_q  <= S_RESP;
						end else if (ordered) begin
							state_q <= S_BREAD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					addr_s1 <= ptr_q;
					if (mem_req.re) begin
						ptr_q <= ptr_p1[kst_pkg::CW-1:0];
					end
				end
				S_BREAD: begin
					mid_s1 <= mid;
					if (!find_done) begin
						state_q <= S_BCMP;
					end
				end
				S_BCMP: begin
					if (!find_done) begin
						if (rdata < key_q) begin
							lo_q <= mid_s1 + {{(kst_pkg::CW-1){1'b0}}, 1'b1};
						end else begin
							hi_q <= mid_s1;
						end
						state_q <= S_BREAD;
					end
				end
				S_SHUP: begin
					addr_s1 <= ptr_q;
					if (mem_req.re) begin
						ptr_q <= ptr_m1;
					end else if (!valid_s1) begin
						status_q <= kst_pkg::ST_DONE;
						newcnt_q <= cnt_p1;
						state_q  <= S_RESP;
					end
				end
				S_SHDN: begin
					addr_s1 <= ptr_q;
					if (mem_req.re) begin
						ptr_q <= ptr_p1[kst_pkg::CW-1:0];
					end else if (!valid_s1) begin
						status_q <= kst_pkg::ST_DONE;
						newcnt_q <= cnt_m1;
						state_q  <= S_RESP;
					end
				end
				S_MVRD: begin
					state_q <= S_MVWR;
				end
				S_MVWR: begin
					status_q <= kst_pkg::ST_DONE;
					newcnt_q <= cnt_m1;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						cnt_q   <= newcnt_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// dispatch once the search pass settles
			if (find_done) begin
				pos_q <= find_pos;
				case (act_q)
					kst_pkg::ACT_INSERT: begin
						if (find_hit) begin
							status_q <= kst_pkg::ST_DUP;
							state_q  <= S_RESP;
						end else begin
							ptr_q   <= cnt_q;
							state_q <= S_SHUP;
						end
					end
					kst_pkg::ACT_REMOVE: begin
						if (!find_hit) begin
							status_q <= kst_pkg::ST_NOTFOUND;
							state_q  <= S_RESP;
						end else if (ordered) begin
							ptr_q   <= find_pos;
							state_q <= S_SHDN;
						end else begin
							state_q <= S_MVRD;
						end
					end
					default: begin
						status_q <= find_hit ? kst_pkg::ST_DONE : kst_pkg::ST_NOTFOUND;
						state_q  <= S_RESP;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

[design/key_set_table_search_insert_remove.sv]
// From accept to result valid, an unordered search scans the stored keys in turn and an
// ordered search bisects them. An insert or ordered remove then shifts the entries from the
// found position onward, an unordered remove moves the last entry into the gap, and full and
// empty refusals skip the search. One item in work at a time, paced by the key RAM read port;
// a result register frees the input.
// Reset clears the key count and ordered mode, sets capacity to 64; the key RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module key_set_table_search_insert_remove (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // key[30:0], zero pad[31]
	input  wire  [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // status[2:0], position[9:3], count[16:10], pad[23:17]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [6:0]  cfg_data
);

	logic                        ordered_q;
	logic [kst_pkg::CAPW-1:0]    cap_q;
	logic [kst_pkg::CW-1:0]      cap_eff;
	logic                        out_free;
	logic [kst_pkg::KW-1:0]      rdata;
	kst_pkg::mem_req_t           mem_req;
	kst_pkg::result_t            res;
	logic                        m_tvalid_q;
	logic [23:0]                 m_tdata_q;

	assign cfg_ready = 1'b1;
	assign cap_eff   = (kst_pkg::CMPW'(cap_q) > kst_pkg::CMPW'(kst_pkg::DEPTH)) ?
		kst_pkg::CW'(kst_pkg::DEPTH) : kst_pkg::CW'(cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_q <= 1'b0;
			cap_q     <= kst_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				kst_pkg::CFG_ORDERED:  ordered_q <= cfg_data[0];
				kst_pkg::CFG_CAPACITY: cap_q     <= cfg_data;
				default:               cap_q     <= cap_q;
			endcase
		end
	end

	kst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.in_key    (s_tdata[kst_pkg::KW-1:0]),
		.ordered   (ordered_q),
		.cap_eff   (cap_eff),
		.out_free  (out_free),
		.mem_req   (mem_req),
		.rdata     (rdata),
		.res       (res)
	);

	kst_ram #(
		.WIDTH (kst_pkg::KW),
		.DEPTH (kst_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// hold the result until taken
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= {7'b0, kst_pkg::RW'(res.count), kst_pkg::RW'(res.position),
				res.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

[design/kst_checker.sv]
// Port-level checks of the key set table, bound to the top level.
// Depends on kst_pkg and key_set_table_search_insert_remove_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "key_set_table_search_insert_remove_assert.svh"

module kst_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [31:0] s_tdata,
	input wire [1:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire        cfg_valid,
	input wire        cfg_ready,
	input wire        cfg_index,
	input wire [6:0]  cfg_data
);

	// hold a stalled result
	`KST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// one item in work: no accept right after an accept
	`KST_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
	`KST_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[2:0] <= 3'd4)
	`KST_ASSERT_NOW(a_count_bound, m_tvalid, m_tdata[16:10] <= 7'(kst_pkg::DEPTH))

endmodule

bind key_set_table_search_insert_remove kst_checker u_kst_checker (.*);

`default_nettype wire
